// ----- hdl/hfta_pkg.sv -----
`timescale 1ns / 1ps
package hfta_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_UNF   = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_ITER,
    S_NORM,
    S_FIN,
    S_OUT
  } state_e;
endpackage

// ----- hdl/hfta_if.sv -----
`timescale 1ns / 1ps
interface hfta_in_if #(
  parameter int EB = 5,
  parameter int FB = 10
);
  logic          valid;
  logic          ready;
  logic [1:0]    opcode;
  logic          a_sign;
  logic [EB-1:0] a_exp;
  logic [FB-1:0] a_frac;
  logic          b_sign;
  logic [EB-1:0] b_exp;
  logic [FB-1:0] b_frac;
  modport source (output valid, opcode, a_sign, a_exp, a_frac, b_sign, b_exp, b_frac,
                  input ready);
  modport sink (input valid, opcode, a_sign, a_exp, a_frac, b_sign, b_exp, b_frac,
                output ready);
  modport monitor (input valid, ready, opcode, a_sign, a_exp, a_frac, b_sign, b_exp,
                   b_frac);
endinterface

interface hfta_out_if #(
  parameter int EB = 5,
  parameter int FB = 10
);
  logic          valid;
  logic          ready;
  logic          res_sign;
  logic [EB-1:0] res_exp;
  logic [FB-1:0] res_frac;
  logic [1:0]    status;
  modport source (output valid, res_sign, res_exp, res_frac, status, input ready);
  modport sink (input valid, res_sign, res_exp, res_frac, status, output ready);
  modport monitor (input valid, ready, res_sign, res_exp, res_frac, status);
endinterface

// ----- hdl/half_float_truncating_alu_top.sv -----
`timescale 1ns / 1ps
// Half-precision add/subtract/multiply/divide with truncation, one item at a
// time. Exponent 0 with fraction 0 is zero; every other code is a normal
// number with a hidden one (no subnormals, infinities or NaNs). A small
// sequencer drives one shared datapath: a shifter that aligns and normalizes
// one place per cycle, a subtractor that also performs restoring division one
// quotient bit per cycle, and one registered multiplier. A zero-operand
// pass-through goes from the accepting edge straight into the output register;
// a multiply registers the product, then normalizes and finishes; a divide
// takes one pre-scale step, FRAC_BITS+1 quotient bits, normalize and finish;
// add/subtract takes the alignment shifts (exponent difference, capped at
// FRAC_BITS+2), the add or subtract, the normalization shifts (one right, or
// up to FRAC_BITS left) and finish. The result then waits in an output
// register until taken, and the input is ready again in the cycle after it is
// taken. The input is not ready while an item is in flight. Zero operands
// pass through, overflow saturates, underflow gives a signed zero, and divide
// by zero returns b with status 3.
module half_float_truncating_alu_top #(
  parameter int EXP_BITS  = 5,
  parameter int FRAC_BITS = 10
) (
  input logic  clk_i,
  input logic  rst_ni,
  hfta_in_if.sink    in_i,
  hfta_out_if.source out_o
);
  localparam int MW = FRAC_BITS + 1;       // mantissa width
  localparam int EW = EXP_BITS + 3;        // signed working exponent
  localparam int CW = $clog2(2 * MW + 4);
  localparam logic signed [EW-1:0] BIAS = EW'((1 << (EXP_BITS - 1)) - 1);
  localparam logic signed [EW-1:0] EMAX = EW'((1 << EXP_BITS) - 1);

  hfta_pkg::state_e state_q, state_d;

  logic                 sign_q, sign_d;
  logic signed [EW-1:0] e_q, e_d;
  logic [MW:0]          m_q, m_d;      // result mantissa, one guard bit on top
  logic [MW:0]          x_q, x_d;      // larger operand / remainder
  logic [MW-1:0]        y_q, y_d;      // operand to align / divisor
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [1:0]           op_q, op_d;
  logic                 sub_q, sub_d;  // effective subtract
  logic [2*MW-1:0]      prod_q;

  logic          o_sign_q, o_sign_d;
  logic [EXP_BITS-1:0]  o_exp_q, o_exp_d;
  logic [FRAC_BITS-1:0] o_frac_q, o_frac_d;
  logic [1:0]    o_st_q, o_st_d;

  logic a_zero, b_zero, bs_eff, acc;
  logic [MW+1:0] diff;

  // pass-through of zero operands straight into the output register
  logic          p_sign;
  logic [EXP_BITS-1:0]  p_exp;
  logic [FRAC_BITS-1:0] p_frac;
  logic [1:0]    p_st;
  logic          p_en;

  assign a_zero = (in_i.a_exp == '0) && (in_i.a_frac == '0);
  assign b_zero = (in_i.b_exp == '0) && (in_i.b_frac == '0);
  assign bs_eff = (in_i.opcode == hfta_pkg::OP_SUB && !b_zero) ? ~in_i.b_sign
                                                                : in_i.b_sign;
  assign in_i.ready = (state_q == hfta_pkg::S_IDLE);
  assign acc = in_i.valid && in_i.ready;
  // shared subtractor: division step and effective subtraction
  assign diff = {1'b0, x_q} - {2'b0, y_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hfta_pkg::S_IDLE: if (acc) state_d = p_en ? hfta_pkg::S_OUT : hfta_pkg::S_ALIGN;
      hfta_pkg::S_ALIGN: begin
        if (op_q == hfta_pkg::OP_DIV) state_d = hfta_pkg::S_ITER;
        else if (op_q == hfta_pkg::OP_MUL) state_d = hfta_pkg::S_NORM;
        else if (cnt_q == '0) state_d = hfta_pkg::S_ITER;
      end
      hfta_pkg::S_ITER: begin
        if (op_q != hfta_pkg::OP_DIV || cnt_q == CW'(1)) state_d = hfta_pkg::S_NORM;
      end
      hfta_pkg::S_NORM: begin
        if (op_q == hfta_pkg::OP_MUL || op_q == hfta_pkg::OP_DIV) state_d = hfta_pkg::S_FIN;
        else if (m_q[MW] == 1'b0 && (m_q[MW-1] || m_q == '0)) state_d = hfta_pkg::S_FIN;
      end
      hfta_pkg::S_FIN: state_d = hfta_pkg::S_OUT;
      hfta_pkg::S_OUT: if (out_o.ready) state_d = hfta_pkg::S_IDLE;
      default: state_d = hfta_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic signed [EW-1:0] ef;
    logic [EW-1:0]        ed;
    sign_d = sign_q; e_d = e_q; m_d = m_q; x_d = x_q; y_d = y_q;
    cnt_d = cnt_q; op_d = op_q; sub_d = sub_q;
    o_sign_d = o_sign_q; o_exp_d = o_exp_q; o_frac_d = o_frac_q; o_st_d = o_st_q;
    ef = '0; ed = '0;
    case (state_q)
      hfta_pkg::S_IDLE: if (acc) begin
        op_d = in_i.opcode;
        sub_d = in_i.a_sign ^ bs_eff;
        cnt_d = '0;
        if (in_i.opcode == hfta_pkg::OP_MUL) begin
          sign_d = in_i.a_sign ^ in_i.b_sign;
          e_d = EW'(in_i.a_exp) + EW'(in_i.b_exp) - BIAS;
          x_d = {2'b01, in_i.a_frac};
          y_d = {1'b1, in_i.b_frac};
        end else if (in_i.opcode == hfta_pkg::OP_DIV) begin
          sign_d = in_i.a_sign ^ in_i.b_sign;
          e_d = EW'(in_i.a_exp) - EW'(in_i.b_exp) + BIAS;
          x_d = {2'b01, in_i.a_frac};
          y_d = {1'b1, in_i.b_frac};
          m_d = '0;
          cnt_d = CW'(MW);
        end else begin
          // add/sub: x takes the larger operand, y the one to be shifted
          if (in_i.a_exp >= in_i.b_exp) begin
            sign_d = in_i.a_sign;
            e_d = EW'(in_i.a_exp);
            x_d = {2'b01, in_i.a_frac};
            y_d = {1'b1, in_i.b_frac};
            ed = EW'(in_i.a_exp - in_i.b_exp);
            // equal exponents, subtract: larger fraction wins
            if (in_i.a_exp == in_i.b_exp && in_i.b_frac > in_i.a_frac) begin
              sign_d = bs_eff;
              x_d = {2'b01, in_i.b_frac};
              y_d = {1'b1, in_i.a_frac};
            end
          end else begin
            sign_d = bs_eff;
            e_d = EW'(in_i.b_exp);
            x_d = {2'b01, in_i.b_frac};
            y_d = {1'b1, in_i.a_frac};
            ed = EW'(in_i.b_exp - in_i.a_exp);
          end
          cnt_d = (ed > EW'(MW + 1)) ? CW'(MW + 1) : CW'(ed);
        end
      end
      hfta_pkg::S_ALIGN: begin
        if (op_q == hfta_pkg::OP_ADD || op_q == hfta_pkg::OP_SUB) begin
          if (cnt_q != '0) begin
            y_d = y_q >> 1;
            cnt_d = cnt_q - 1'b1;
          end
        end else if (op_q == hfta_pkg::OP_DIV) begin
          // quotient exponent adjust: ensure dividend >= divisor
          if (x_q[MW-1:0] < y_q) begin
            x_d = x_q << 1;
            e_d = e_q - 1'b1;
          end
        end
      end
      hfta_pkg::S_ITER: begin
        if (op_q == hfta_pkg::OP_DIV) begin
          // one restoring division step
          if (!diff[MW+1]) begin
            m_d = {m_q[MW-1:0], 1'b1};
            x_d = {diff[MW-1:0], 1'b0};
          end else begin
            m_d = {m_q[MW-1:0], 1'b0};
            x_d = {x_q[MW-1:0], 1'b0};
          end
          cnt_d = cnt_q - 1'b1;
        end else if (sub_q) begin
          m_d = diff[MW:0];
        end else begin
          m_d = x_q + {1'b0, y_q};
        end
      end
      hfta_pkg::S_NORM: begin
        if (op_q == hfta_pkg::OP_MUL) begin
          if (prod_q[2*MW-1]) begin
            m_d = {1'b0, prod_q[2*MW-1 -: MW]};
            e_d = e_q + 1'b1;
          end else begin
            m_d = {1'b0, prod_q[2*MW-2 -: MW]};
          end
        end else if (op_q == hfta_pkg::OP_ADD || op_q == hfta_pkg::OP_SUB) begin
          if (m_q[MW]) begin
            m_d = m_q >> 1;
            e_d = e_q + 1'b1;
          end else if (!m_q[MW-1] && m_q != '0) begin
            m_d = m_q << 1;
            e_d = e_q - 1'b1;
          end
        end
      end
      hfta_pkg::S_FIN: begin
        o_sign_d = sign_q;
        ef = e_q;
        if (m_q == '0) begin
          // exact cancellation
          o_sign_d = 1'b0; o_exp_d = '0; o_frac_d = '0; o_st_d = hfta_pkg::ST_OK;
        end else if (ef > EMAX) begin
          o_exp_d = '1; o_frac_d = '1; o_st_d = hfta_pkg::ST_OVF;
        end else if (ef < 0 || (ef == 0 && m_q[FRAC_BITS-1:0] == '0)) begin
          o_exp_d = '0; o_frac_d = '0; o_st_d = hfta_pkg::ST_UNF;
        end else begin
          o_exp_d = ef[EXP_BITS-1:0];
          o_frac_d = m_q[FRAC_BITS-1:0];
          o_st_d = hfta_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    p_en = 1'b0; p_sign = 1'b0; p_exp = '0; p_frac = '0; p_st = hfta_pkg::ST_OK;
    if (in_i.opcode == hfta_pkg::OP_DIV && (a_zero || b_zero)) begin
      p_en = 1'b1;
      p_sign = b_zero ? in_i.b_sign : in_i.a_sign;
      p_exp = b_zero ? in_i.b_exp : in_i.a_exp;
      p_frac = b_zero ? in_i.b_frac : in_i.a_frac;
      p_st = b_zero ? hfta_pkg::ST_DIVZ : hfta_pkg::ST_OK;
    end else if (in_i.opcode == hfta_pkg::OP_MUL && (a_zero || b_zero)) begin
      p_en = 1'b1;
      p_sign = a_zero ? in_i.a_sign : in_i.b_sign;
      p_exp = a_zero ? in_i.a_exp : in_i.b_exp;
      p_frac = a_zero ? in_i.a_frac : in_i.b_frac;
    end else if (in_i.opcode[1] == 1'b0 && (a_zero || b_zero)) begin
      p_en = 1'b1;
      p_sign = a_zero ? bs_eff : in_i.a_sign;
      p_exp = a_zero ? in_i.b_exp : in_i.a_exp;
      p_frac = a_zero ? in_i.b_frac : in_i.a_frac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hfta_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d; e_q <= e_d; m_q <= m_d; x_q <= x_d; y_q <= y_d;
    cnt_q <= cnt_d; op_q <= op_d; sub_q <= sub_d;
    prod_q <= x_q[MW-1:0] * y_q;
    if (state_q == hfta_pkg::S_IDLE && acc && p_en) begin
      o_sign_q <= p_sign; o_exp_q <= p_exp; o_frac_q <= p_frac; o_st_q <= p_st;
    end else begin
      o_sign_q <= o_sign_d; o_exp_q <= o_exp_d; o_frac_q <= o_frac_d; o_st_q <= o_st_d;
    end
  end

  assign out_o.valid    = (state_q == hfta_pkg::S_OUT);
  assign out_o.res_sign = o_sign_q;
  assign out_o.res_exp  = o_exp_q;
  assign out_o.res_frac = o_frac_q;
  assign out_o.status   = o_st_q;

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(o_st_q))
    else $error("result dropped");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hfta_pkg::S_ITER && op_q == hfta_pkg::OP_DIV) |-> cnt_q != '0)
    else $error("divide counter underrun");
`endif
endmodule
